>>> design/stl_pkg.sv
package stl_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_DUMPED   = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ROTATE = 2'd2
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t         cmd;
        logic [VAL_W-1:0]  new_value;
    } cell_ctrl_t;

endpackage

>>> design/sorted_table_insert.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall   operation, value
// out      out_valid / out_stall status, element, occupancy, is_last
//
// On an insert every cell compares against the new value at once
// and the chain shifts right by one place from the insertion point.
// A dump emits the held values one result per rotation of the cell chain past its head,
// pausing while the output is stalled; no item is accepted meanwhile.
// Reset clears the fill count and the control state; cell contents are not reset.
// A stalled output holds its result and the input stalls until it is taken.
module sorted_table_insert (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] element,
    output logic [6:0]  occupancy,
    output logic        is_last
);

    localparam int N  = stl_pkg::CAPACITY;
    localparam int CW = stl_pkg::CNT_W;
    localparam int IW = stl_pkg::IDX_W;
    localparam int VW = stl_pkg::VAL_W;

    stl_pkg::state_t     state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    stl_pkg::status_t    status_reg, status_next;
    logic [VW-1:0]       element_reg, element_next;
    logic [CW-1:0]       occupancy_reg, occupancy_next;
    logic                is_last_reg, is_last_next;

    stl_pkg::cell_ctrl_t ctrl;
    logic [VW-1:0]       cell_value [N];
    logic                cell_gt    [N];
    logic                cell_occ   [N];
    logic                out_free;
    logic                accept;
    logic                dump_last;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            assign cell_occ[g] = count_reg > CW'(g);
            stl_cell u_cell (
                .clk           (clk),
                .ctrl          (ctrl),
                .occupied      (cell_occ[g]),
                .wrap          (count_reg == CW'(g + 1)),
                .prev_occupied ((g == 0) ? 1'b1 : cell_occ[(g == 0) ? 0 : g - 1]),
                .prev_gt       ((g == 0) ? 1'b0 : cell_gt[(g == 0) ? 0 : g - 1]),
                .prev_value    (cell_value[(g == 0) ? 0 : g - 1]),
                .next_value    (cell_value[(g == N - 1) ? 0 : g + 1]),
                .head_value    (cell_value[0]),
                .gt            (cell_gt[g]),
                .value         (cell_value[g])
            );
        end
    endgenerate

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != stl_pkg::S_IDLE) || !out_free;
    assign accept    = in_valid && !in_stall;
    assign dump_last = CW'(idx_reg) == (count_reg - CW'(1));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        element_next   = element_reg;
        occupancy_next = occupancy_reg;
        is_last_next   = is_last_reg;
        ctrl.cmd       = stl_pkg::CMD_HOLD;
        ctrl.new_value = value;

        unique case (state_reg)
            stl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == stl_pkg::OP_INSERT)
                    begin
                        out_valid_next = 1'b1;
                        element_next   = '0;
                        is_last_next   = 1'b1;
                        if (count_reg >= CW'(N))
                        begin
                            status_next    = stl_pkg::ST_FULL;
                            occupancy_next = count_reg;
                        end
                        else
                        begin
                            ctrl.cmd       = stl_pkg::CMD_INSERT;
                            count_next     = count_reg + CW'(1);
                            status_next    = stl_pkg::ST_INSERTED;
                            occupancy_next = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = stl_pkg::ST_EMPTY;
                        element_next   = '0;
                        occupancy_next = '0;
                        is_last_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = stl_pkg::S_DUMP;
                        idx_next   = '0;
                    end
                end
            end
            stl_pkg::S_DUMP:
            begin
                if (out_free)
                begin
                    ctrl.cmd       = stl_pkg::CMD_ROTATE;
                    out_valid_next = 1'b1;
                    status_next    = stl_pkg::ST_DUMPED;
                    element_next   = cell_value[0];
                    occupancy_next = count_reg;
                    is_last_next   = dump_last;
                    idx_next       = idx_reg + IW'(1);
                    if (dump_last)
                    begin
                        state_next = stl_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = stl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stl_pkg::S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        element_reg   <= element_next;
        occupancy_reg <= occupancy_next;
        is_last_reg   <= is_last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign occupancy = occupancy_reg;
    assign is_last   = is_last_reg;

endmodule

>>> design/stl_cell.sv
module stl_cell (
    input  logic                      clk,
    input  stl_pkg::cell_ctrl_t       ctrl,
    input  logic                      occupied,
    input  logic                      wrap,
    input  logic                      prev_occupied,
    input  logic                      prev_gt,
    input  logic [stl_pkg::VAL_W-1:0] prev_value,
    input  logic [stl_pkg::VAL_W-1:0] next_value,
    input  logic [stl_pkg::VAL_W-1:0] head_value,
    output logic                      gt,
    output logic [stl_pkg::VAL_W-1:0] value
);

    logic [stl_pkg::VAL_W-1:0] value_reg;
    logic [stl_pkg::VAL_W-1:0] value_next;
    logic                      take_new;

    // A held value strictly above the new one moves right; equal values stay put.
    assign gt       = occupied && ($signed(value_reg) > $signed(ctrl.new_value));
    assign take_new = (gt || !occupied) && prev_occupied && !prev_gt;
    assign value    = value_reg;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.cmd)
            stl_pkg::CMD_INSERT:
            begin
                if (prev_gt)
                begin
                    value_next = prev_value;
                end
                else if (take_new)
                begin
                    value_next = ctrl.new_value;
                end
            end
            stl_pkg::CMD_ROTATE:
            begin
                // The last held cell takes the head so that a full pass restores the order.
                value_next = wrap ? head_value : next_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

>>> design/stl_checker.sv
module stl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [31:0] element,
    input logic [6:0]  occupancy,
    input logic        is_last
);

    // A dropped insert only happens with the table at capacity.
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == stl_pkg::ST_FULL) |-> occupancy == 7'(stl_pkg::CAPACITY))
        else $error("full result without a full table");

    // Every result other than a dumped element is the only one of its item.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != stl_pkg::ST_DUMPED) |-> (is_last && element == '0))
        else $error("single result not marked last or element not zero");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= 7'(stl_pkg::CAPACITY))
        else $error("occupancy above capacity");

    // Within a dump the occupancy does not change from one element to the next.
    a_dump_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && status == stl_pkg::ST_DUMPED && !is_last
            ##1 out_valid) |-> (status == stl_pkg::ST_DUMPED && $stable(occupancy)))
        else $error("dump interrupted or occupancy changed");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(element) && $stable(status)))
        else $error("stalled result changed");

endmodule

bind sorted_table_insert stl_checker u_stl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .element   (element),
    .occupancy (occupancy),
    .is_last   (is_last)
);
